FILE: rtl/encoder_position_bar_graph_core_defines.svh
// ----------------------------------------------------------------------------
// encoder_position_bar_graph_core_defines.svh
// Assertion macros used by the port-level checker of the encoder bar block.
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_BAR_GRAPH_CORE_DEFINES_SVH
`define ENCODER_POSITION_BAR_GRAPH_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EPBG_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define EPBG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/epbg_pkg.sv
// ----------------------------------------------------------------------------
// epbg_pkg
// Shared widths, register codes, state type and bar helper for the encoder
// position tracker.
// ----------------------------------------------------------------------------
package epbg_pkg;

    localparam int NUM_ENCODERS_DEF = 16;

    localparam int IDX_W    = 4;    // encoder index field
    localparam int POS_W    = 16;   // positions, deltas, range registers
    localparam int BAR_W    = 16;   // thermometer pattern
    localparam int LEVEL_W  = 4;    // bar level 0..15
    localparam int EXT_W    = POS_W + 1;       // exact sums and differences
    localparam int NUM_W    = EXT_W + 3;       // (pos - min) * 15 fits here
    localparam int STEP_W   = $clog2(LEVEL_W);

    // Configuration register codes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 1'b1;

    localparam logic signed [POS_W-1:0] RANGE_MIN_RST = 16'sd0;
    localparam logic signed [POS_W-1:0] RANGE_MAX_RST = 16'sd100;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 4'd15;
    localparam logic [BAR_W-1:0]   FULL_BAR  = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_DIFF,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } epbg_state_t;

    // Thermometer pattern: bits 0..level set
    function automatic logic [BAR_W-1:0] bar_of(input logic [LEVEL_W-1:0] level);
        return FULL_BAR >> (LEVEL_TOP - level);
    endfunction

endpackage

FILE: rtl/epbg_in_if.sv
// ----------------------------------------------------------------------------
// epbg_in_if
// Input channel: one word is an encoder index and a signed count delta.
// ----------------------------------------------------------------------------
interface epbg_in_if
    import epbg_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        encoder_index;
    logic signed [POS_W-1:0] count_delta;

    modport source (output valid, output encoder_index, output count_delta, input ready);
    modport sink   (input valid, input encoder_index, input count_delta, output ready);
endinterface

FILE: rtl/epbg_out_if.sv
// ----------------------------------------------------------------------------
// epbg_out_if
// Output channel: one word is the encoder, its new position and its bar.
// ----------------------------------------------------------------------------
interface epbg_out_if
    import epbg_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        source_index;
    logic signed [POS_W-1:0] new_position;
    logic [BAR_W-1:0]        bar_pattern;

    modport source (output valid, output source_index, output new_position,
                    output bar_pattern, input ready);
    modport sink   (input valid, input source_index, input new_position,
                    input bar_pattern, output ready);
endinterface

FILE: rtl/encoder_position_bar_graph_core.sv
// ----------------------------------------------------------------------------
// encoder_position_bar_graph_core
// Per-encoder saturating position accumulator with a thermometer bar output.
//
//   channel   | dir | word
//   ----------+-----+---------------------------------------------
//   item_in   | in  | encoder_index, count_delta
//   result_out| out | source_index, new_position, bar_pattern
//   cfg_*     | in  | range_min (0), range_max (1), write only
//
// One word at a time: a nonzero delta passes from accept to result through
// read, add/clamp, offset, scale, 4 divider steps and hand-off; the bar level
// comes from a restoring divider that retires one quotient bit per cycle.
// Zero deltas and out-of-range indexes are dropped in the read state.
// The result register lets the next word in while a result waits; a finished
// word that finds the result register still full waits in the hand-off state.
// Reset clears per-encoder valid bits at once, so positions read as zero.
// ----------------------------------------------------------------------------
module encoder_position_bar_graph_core
    import epbg_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    epbg_in_if.sink              item_in,
    epbg_out_if.source           result_out
);

    localparam int AW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
    localparam int WIDE_W = AW + IDX_W;

    // Configuration
    logic signed [POS_W-1:0] range_min_reg;
    logic signed [POS_W-1:0] range_max_reg;

    // Control
    epbg_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   cnt_reg;
    logic                out_valid_reg;
    logic [NUM_ENCODERS-1:0] valid_reg;

    // Position store
    logic [POS_W-1:0]    pos_mem [NUM_ENCODERS];

    // Datapath
    logic [IDX_W-1:0]        idx_reg;
    logic signed [POS_W-1:0] delta_reg;
    logic [POS_W-1:0]        rd_data_reg;
    logic                    rd_valid_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic [EXT_W-1:0]        diff_reg;
    logic [EXT_W-1:0]        span_reg;
    logic                    span_ok_reg;
    logic [NUM_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        dvs_reg;
    logic [LEVEL_W-1:0]      quo_reg;

    logic [IDX_W-1:0]        out_idx_reg;
    logic signed [POS_W-1:0] out_pos_reg;
    logic [BAR_W-1:0]        out_bar_reg;

    // Control strobes
    logic accept;
    logic drop;
    logic load_out;

    // Address decode
    logic [WIDE_W-1:0] in_wide, held_wide;
    logic [AW-1:0]     in_addr, wr_addr;
    logic              in_range;

    assign in_wide   = {{AW{1'b0}}, item_in.encoder_index};
    assign held_wide = {{AW{1'b0}}, idx_reg};
    assign in_addr   = in_wide[AW-1:0];
    assign wr_addr   = held_wide[AW-1:0];
    assign in_range  = held_wide < WIDE_W'(NUM_ENCODERS);
    assign drop      = (delta_reg == '0) || !in_range;

    // Add and clamp: max first, then min
    logic signed [EXT_W-1:0] cur_ext, sum_ext, max_ext, min_ext, clip_hi, clip_lo;

    assign cur_ext = rd_valid_reg ? {rd_data_reg[POS_W-1], rd_data_reg} : '0;
    assign max_ext = {range_max_reg[POS_W-1], range_max_reg};
    assign min_ext = {range_min_reg[POS_W-1], range_min_reg};
    assign sum_ext = cur_ext + {delta_reg[POS_W-1], delta_reg};
    assign clip_hi = (sum_ext >= max_ext) ? max_ext : sum_ext;
    assign clip_lo = (clip_hi <= min_ext) ? min_ext : clip_hi;

    // Offset into the range and range span
    logic signed [EXT_W-1:0] pos_ext;
    assign pos_ext = {pos_reg[POS_W-1], pos_reg};

    // Numerator (pos - min) * 15 as (d << 4) - d
    logic [NUM_W:0] num_full;
    assign num_full = {diff_reg, 4'b0000} - {4'b0000, diff_reg};

    // One restoring divider step
    logic             q_bit;
    logic [NUM_W-1:0] rem_sub;
    assign q_bit   = rem_reg >= dvs_reg;
    assign rem_sub = rem_reg - dvs_reg;

    logic [LEVEL_W-1:0] level;
    assign level = span_ok_reg ? quo_reg : '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (item_in.valid) state_next = ST_READ;
            ST_READ:  state_next = drop ? ST_IDLE : ST_ADD;
            ST_ADD:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == STEP_W'(LEVEL_W - 1)) state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || result_out.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // State-driven strobes
    always_comb
    begin
        item_in.ready = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: item_in.ready = 1'b1;
            ST_DONE: load_out = !out_valid_reg || result_out.ready;
            default: ;
        endcase
    end

    assign accept = item_in.valid && item_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= RANGE_MIN_RST;
            range_max_reg <= RANGE_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_MIN: range_min_reg <= cfg_data;
                REG_RANGE_MAX: range_max_reg <= cfg_data;
            endcase
        end
    end

    // Divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == ST_SCALE)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            cnt_reg <= cnt_reg + STEP_W'(1);
        end
    end

    // Per-encoder written flags; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (state_reg == ST_ADD)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Position memory: one write port, one registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADD)
        begin
            pos_mem[wr_addr] <= clip_lo[POS_W-1:0];
        end
        if (accept)
        begin
            rd_data_reg  <= pos_mem[in_addr];
            rd_valid_reg <= valid_reg[in_addr];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= item_in.encoder_index;
            delta_reg <= item_in.count_delta;
        end
        if (state_reg == ST_ADD)
        begin
            pos_reg <= clip_lo[POS_W-1:0];
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg    <= pos_ext - min_ext;
            span_reg    <= max_ext - min_ext;
            span_ok_reg <= range_max_reg > range_min_reg;
        end
        if (state_reg == ST_SCALE)
        begin
            rem_reg <= num_full[NUM_W-1:0];
            dvs_reg <= {span_reg, 3'b000};
            quo_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            if (q_bit)
            begin
                rem_reg <= rem_sub;
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[LEVEL_W-2:0], q_bit};
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_idx_reg <= idx_reg;
            out_pos_reg <= pos_reg;
            out_bar_reg <= bar_of(level);
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.source_index = out_idx_reg;
    assign result_out.new_position = out_pos_reg;
    assign result_out.bar_pattern  = out_bar_reg;

endmodule

FILE: rtl/epbg_checker.sv
// ----------------------------------------------------------------------------
// epbg_checker
// Port-level checks for the encoder position tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "encoder_position_bar_graph_core_defines.svh"

module epbg_checker
    import epbg_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [BAR_W-1:0] bar_pattern
);

    // A waiting result word is not withdrawn
    `EPBG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")

    // Only one word in flight: no accept in the cycle after an accept
    `EPBG_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second word taken while busy")

    // A result never appears right after an accept
    `EPBG_ASSERT_NOW(a_no_early_result, clk, rst_n, $rose(out_valid), !$past(in_valid && in_ready), "result too early")

    // Bar is a thermometer with bit 0 always lit
    `EPBG_ASSERT_NOW(a_bar_shape, clk, rst_n, out_valid, bar_pattern[0] && ((bar_pattern & (bar_pattern + 16'd1)) == 16'd0), "bar not a thermometer")

endmodule

bind encoder_position_bar_graph_core epbg_checker u_epbg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item_in.valid),
    .in_ready    (item_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .bar_pattern (result_out.bar_pattern)
);

FILE: tb/epbg_bar_checker.sv
// ----------------------------------------------------------------------------
// epbg_bar_checker
// Watches the configuration port and both channels of the encoder bar block.
// It keeps its own copy of the range registers and the per-encoder positions.
// Each accepted input word with a nonzero delta and a known encoder gets an
// expected result word; each output word is compared with the oldest one.
// It reports the failure count and the number of result words still due.
// ----------------------------------------------------------------------------
module epbg_bar_checker
    import epbg_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    epbg_in_if                   item_mon,
    epbg_out_if                  result_mon,
    output int                   fail_count,
    output int                   words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0]        source_index;
        logic signed [POS_W-1:0] new_position;
        logic [BAR_W-1:0]        bar_pattern;
    } bar_word_t;

    logic signed [POS_W-1:0] floor_pos;
    logic signed [POS_W-1:0] ceil_pos;
    logic signed [POS_W-1:0] positions [NUM_ENCODERS];
    bar_word_t               bar_words_due [$];

    // Bar level scaled over the range, truncated and kept within 0..15
    function automatic logic [BAR_W-1:0] thermometer(input int pos);
        int span;
        int level;
        span  = int'(ceil_pos) - int'(floor_pos);
        level = 0;
        if (span > 0)
            level = ((pos - int'(floor_pos)) * 15) / span;
        if (level < 0)
            level = 0;
        if (level > 15)
            level = 15;
        return 16'hFFFF >> (15 - level);
    endfunction

    // Add the delta exactly, clamp to max then min, store, form the word
    function automatic bar_word_t settle_position(input logic [IDX_W-1:0] idx,
                                                  input logic signed [POS_W-1:0] delta);
        bar_word_t word;
        int        sum;
        sum = int'(positions[idx]) + int'(delta);
        if (sum >= int'(ceil_pos))
            sum = int'(ceil_pos);
        if (sum <= int'(floor_pos))
            sum = int'(floor_pos);
        positions[idx]    = sum[POS_W-1:0];
        word.source_index = idx;
        word.new_position = sum[POS_W-1:0];
        word.bar_pattern  = thermometer(sum);
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bar_word_t due;
        if (!rst_n)
        begin
            floor_pos = RANGE_MIN_RST;
            ceil_pos  = RANGE_MAX_RST;
            for (int k = 0; k < NUM_ENCODERS; k++)
                positions[k] = '0;
            bar_words_due.delete();
            fail_count    = 0;
            words_pending = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == REG_RANGE_MIN)
                    floor_pos = cfg_data;
                else if (cfg_index == REG_RANGE_MAX)
                    ceil_pos = cfg_data;
            end

            // accepted input word: zero deltas and unknown encoders give nothing
            if (item_mon.valid && item_mon.ready && item_mon.count_delta != 0
                && int'(item_mon.encoder_index) < NUM_ENCODERS)
                bar_words_due.push_back(settle_position(item_mon.encoder_index,
                                                        item_mon.count_delta));

            // accepted result word
            if (result_mon.valid && result_mon.ready)
            begin
                if (bar_words_due.size() == 0)
                begin
                    $error("result word for encoder %0d with none expected",
                           result_mon.source_index);
                    fail_count++;
                end
                else
                begin
                    due = bar_words_due.pop_front();
                    if (result_mon.source_index !== due.source_index)
                    begin
                        $error("source_index: expected %0d, actual %0d",
                               due.source_index, result_mon.source_index);
                        fail_count++;
                    end
                    if (result_mon.new_position !== due.new_position)
                    begin
                        $error("new_position: expected %0d, actual %0d",
                               $signed(due.new_position), $signed(result_mon.new_position));
                        fail_count++;
                    end
                    if (result_mon.bar_pattern !== due.bar_pattern)
                    begin
                        $error("bar_pattern: expected %h, actual %h",
                               due.bar_pattern, result_mon.bar_pattern);
                        fail_count++;
                    end
                end
            end
            words_pending = bar_words_due.size();
        end
    end

endmodule

FILE: tb/encoder_position_bar_graph_core_test.sv
// ----------------------------------------------------------------------------
// encoder_position_bar_graph_core_test
// Stimulus and verdict for the encoder position tracker. A directed part hits
// clamping at both ends, zero deltas, inverted and empty ranges and positions
// left outside a changed range; then random words run under a series of range
// settings while both sides idle and stall. Checking is done by the checker.
// ----------------------------------------------------------------------------
module encoder_position_bar_graph_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import epbg_pkg::*;

    localparam int LIMIT_CYCLES      = 400000;
    localparam int DRAIN_CYCLES      = 12;
    localparam int WORDS_PER_SEGMENT = 55;
    localparam int SEGMENTS          = 9;
    localparam int HOLD_CYCLES       = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0]     cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int fail_count;
    int words_pending;
    int cycle_count = 0;

    epbg_in_if  item_bus ();
    epbg_out_if result_bus ();

    encoder_position_bar_graph_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_in    (item_bus),
        .result_out (result_bus)
    );

    epbg_bar_checker bar_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_mon      (item_bus),
        .result_mon    (result_bus),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: long hold-off when requested, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left        <= hold_left - 1;
        end
        else
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one word, with random idle cycles first; returns after acceptance
    task automatic send_word(input logic [IDX_W-1:0] idx,
                             input logic signed [POS_W-1:0] delta);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        item_bus.valid         <= 1'b1;
        item_bus.encoder_index <= idx;
        item_bus.count_delta   <= delta;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
    endtask

    // Stop offering, wait for every result, then let dropped words clear
    task automatic drain();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        wait (words_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_range(input logic signed [POS_W-1:0] lo,
                             input logic signed [POS_W-1:0] hi);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RANGE_MIN;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= REG_RANGE_MAX;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Small steps most often, so positions wander inside the range, some zeros,
    // some wide jumps and full-width values that hit both clamps
    function automatic logic signed [POS_W-1:0] pick_delta();
        int unsigned roll;
        int          step;
        roll = $urandom_range(99);
        if (roll < 10)
            step = 0;
        else if (roll < 55)
            step = int'($urandom_range(40)) - 20;
        else if (roll < 75)
            step = int'($urandom_range(4000)) - 2000;
        else
            step = int'($urandom);
        return step[POS_W-1:0];
    endfunction

    initial
    begin
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] swap;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_RANGE_MIN;
        cfg_data               = '0;
        item_bus.valid         = 1'b0;
        item_bus.encoder_index = '0;
        item_bus.count_delta   = '0;
        result_bus.ready       = 1'b0;
        hold_left              = 0;
        send_idle_pct          = 27;
        recv_idle_pct          = 71;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset range 0..100
        send_word(4'd0, 16'sd1);
        send_word(4'd0, 16'sd32767);
        send_word(4'd0, -16'sd32768);
        send_word(4'd15, 16'sd0);
        send_word(4'd15, -16'sd1);
        send_word(4'd15, 16'sd50);
        send_word(4'd5, 16'sd100);
        send_word(4'd9, 16'sd99);

        // full 16-bit range: exact sums beyond the word width
        set_range(-16'sd32768, 16'sd32767);
        send_word(4'd1, 16'sd32767);
        send_word(4'd1, 16'sd32767);
        send_word(4'd2, -16'sd32768);
        send_word(4'd2, -16'sd32768);
        send_word(4'd3, -16'sd1);

        // inverted range lands on the minimum, empty range too
        set_range(16'sd10, -16'sd10);
        send_word(4'd4, 16'sd5);
        send_word(4'd4, -16'sd32768);
        set_range(16'sd7, 16'sd7);
        send_word(4'd6, 16'sd1);

        // positions left outside the restored range get clamped on next step
        set_range(RANGE_MIN_RST, RANGE_MAX_RST);
        send_word(4'd1, -16'sd1);
        send_word(4'd2, 16'sd1);

        // random segments, each under its own range setting
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            lo = POS_W'($urandom);
            hi = POS_W'($urandom);
            case (seg)
                0: set_range(-16'sd32768, 16'sd32767);
                1: set_range(-16'sd50, 16'sd50);
                2:
                begin
                    if (lo > hi)
                    begin
                        swap = lo;
                        lo   = hi;
                        hi   = swap;
                    end
                    set_range(lo, hi);
                end
                3: set_range(16'sd32767, -16'sd32768);
                4: set_range(-16'sd32768, -16'sd32700);
                5: set_range(16'sd10, 16'sd10);
                6: set_range(-16'sd200, 16'sd300);
                7: set_range(lo, hi);
                default: set_range(RANGE_MIN_RST, RANGE_MAX_RST);
            endcase

            if (seg < 3)
            begin
                send_idle_pct = 27;
                recv_idle_pct = 71;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 27;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // receiver holds off while the sender keeps offering
            if (seg == 6)
            begin
                @(posedge clk);
                hold_left = HOLD_CYCLES;
            end

            repeat (WORDS_PER_SEGMENT)
                send_word(4'($urandom_range(15)), pick_delta());
        end

        drain();
        if (fail_count == 0 && words_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/epbg_pkg.sv
rtl/epbg_in_if.sv
rtl/epbg_out_if.sv
rtl/encoder_position_bar_graph_core.sv
rtl/epbg_checker.sv
tb/epbg_bar_checker.sv
tb/encoder_position_bar_graph_core_test.sv
